// File: rtl/wpid_pkg.sv
// ----------------------------------------------------------------------------
// wpid_pkg
// Shared widths, register indexes and bundle types of the windowed PID
// line tracer.
// ----------------------------------------------------------------------------
package wpid_pkg;

    // Number of errors held in the sliding window.
    localparam int WINDOW = 5;

    localparam int LEVEL_W = 7;                          // midpoint and light sample
    localparam int GAIN_W  = 16;                         // unsigned Q8.8 gains
    localparam int ERR_W   = 8;                          // signed error
    localparam int DIFF_W  = ERR_W + 1;                  // signed error difference
    localparam int SUM_W   = ERR_W + $clog2(WINDOW);     // signed window sum
    localparam int OUT_W   = 27;                         // signed Q.8 result

    localparam int PPROD_W = GAIN_W + 1 + ERR_W;
    localparam int IPROD_W = GAIN_W + 1 + SUM_W;
    localparam int DPROD_W = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W   = IPROD_W + 2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = GAIN_W;

    localparam int S_TDATA_W = ((LEVEL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_MIDPOINT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PROP     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEG    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DERIV    = 2'd3;

    typedef struct packed {
        logic [GAIN_W-1:0] prop;
        logic [GAIN_W-1:0] integ;
        logic [GAIN_W-1:0] deriv;
    } gains_t;

    // Operands handed from the window stage to the multiply stage.
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  sum;
        logic signed [DIFF_W-1:0] diff;
    } operands_t;

    typedef struct packed {
        logic signed [PPROD_W-1:0] p;
        logic signed [IPROD_W-1:0] i;
        logic signed [DPROD_W-1:0] d;
    } products_t;

endpackage

// File: rtl/windowed_pid_line_tracer.sv
// ----------------------------------------------------------------------------
// windowed_pid_line_tracer
// PID steering controller with a sliding-window integral term.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Width  Contents (lowest bit first)
//  -------  ---------  -----  --------------------------------------------
//  s_*      in         8      light_sample[6:0], zero pad
//  m_*      out        32     steer_fixed[26:0] signed Q.8, zero pad
//  cfg_*    in         2+16   register index, write data
//
// One beat is accepted per clock cycle while s_tready is high. The error,
// window sum and difference of a sample are registered at the edge that
// takes its beat, and its result is registered, raising m_tvalid, when
// the multiply stage takes it. Each stage holds its beat while the stage
// after it is full and stalled, so a stall on m_tready fills both registers
// before s_tready drops. Reset is synchronous and active low: it clears the
// error window, the previous error and all valid flags, and loads the
// register defaults.
//
module windowed_pid_line_tracer (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Sample stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [wpid_pkg::S_TDATA_W-1:0]      s_tdata,   // light_sample[6:0]
    // Steering result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wpid_pkg::M_TDATA_W-1:0]      m_tdata,   // steer_fixed[26:0]
    // Register write port.
    input  logic                                cfg_wr_en,
    input  logic [wpid_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [wpid_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    logic [wpid_pkg::LEVEL_W-1:0]       midpoint_reg;
    wpid_pkg::gains_t                   gains_reg;
    logic                               op_valid;
    logic                               op_ready;
    wpid_pkg::operands_t                op;
    logic signed [wpid_pkg::OUT_W-1:0]  steer;

    // Configuration registers. The user sends writes only while the pipeline is empty; the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            midpoint_reg    <= '0;
            gains_reg.prop  <= wpid_pkg::GAIN_W'(198);
            gains_reg.integ <= wpid_pkg::GAIN_W'(166);
            gains_reg.deriv <= wpid_pkg::GAIN_W'(96);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                wpid_pkg::REG_MIDPOINT: begin
                    midpoint_reg <= cfg_wr_data[wpid_pkg::LEVEL_W-1:0];
                end
                wpid_pkg::REG_PROP:  gains_reg.prop  <= cfg_wr_data;
                wpid_pkg::REG_INTEG: gains_reg.integ <= cfg_wr_data;
                wpid_pkg::REG_DERIV: gains_reg.deriv <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Error, window sum and difference for each accepted sample.
    wpid_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sample   (s_tdata[wpid_pkg::LEVEL_W-1:0]),
        .midpoint (midpoint_reg),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    // Gain products and their sum.
    wpid_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .gains     (gains_reg),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (steer)
    );

    assign m_tdata = {{(wpid_pkg::M_TDATA_W - wpid_pkg::OUT_W){1'b0}}, steer};

endmodule

// File: rtl/wpid_window.sv
// ----------------------------------------------------------------------------
// wpid_window
// Forms the error of each sample, keeps the error window as a shift line
// with a running sum, and registers error, window sum and difference.
// ----------------------------------------------------------------------------
module wpid_window (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [wpid_pkg::LEVEL_W-1:0]        sample,
    input  logic [wpid_pkg::LEVEL_W-1:0]        midpoint,
    output logic                                op_valid,
    input  logic                                op_ready,
    output wpid_pkg::operands_t                 op
);

    logic signed [wpid_pkg::ERR_W-1:0]  taps_reg [wpid_pkg::WINDOW];
    logic signed [wpid_pkg::ERR_W-1:0]  prev_reg;
    logic signed [wpid_pkg::SUM_W-1:0]  sum_reg;
    logic signed [wpid_pkg::SUM_W-1:0]  sum_next;
    logic signed [wpid_pkg::ERR_W-1:0]  err;
    logic                               op_valid_reg;
    wpid_pkg::operands_t                op_reg;
    wpid_pkg::operands_t                op_next;
    logic                               take;

    assign in_ready = !op_valid_reg || op_ready;
    assign take     = in_valid && in_ready;
    assign op_valid = op_valid_reg;
    assign op       = op_reg;

    always_comb begin
        err = $signed({1'b0, midpoint}) - $signed({1'b0, sample});
        // The oldest error leaves the window as the new one enters.
        sum_next = sum_reg + wpid_pkg::SUM_W'(err)
                 - wpid_pkg::SUM_W'(taps_reg[wpid_pkg::WINDOW-1]);
        op_next.err  = err;
        op_next.sum  = sum_next;
        op_next.diff = wpid_pkg::DIFF_W'(err) - wpid_pkg::DIFF_W'(prev_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < wpid_pkg::WINDOW; k++) begin
                taps_reg[k] <= '0;
            end
            prev_reg     <= '0;
            sum_reg      <= '0;
            op_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                taps_reg[0] <= err;
                for (int k = 1; k < wpid_pkg::WINDOW; k++) begin
                    taps_reg[k] <= taps_reg[k-1];
                end
                prev_reg <= err;
                sum_reg  <= sum_next;
            end
            if (in_ready) begin
                op_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            op_reg <= op_next;
        end
    end

endmodule

// File: rtl/wpid_mac.sv
// ----------------------------------------------------------------------------
// wpid_mac
// Multiplies the three operands by their gains in parallel and adds the
// products into the result register.
// ----------------------------------------------------------------------------
module wpid_mac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                op_valid,
    output logic                                op_ready,
    input  wpid_pkg::operands_t                 op,
    input  wpid_pkg::gains_t                    gains,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic signed [wpid_pkg::OUT_W-1:0]   res
);

    wpid_pkg::products_t                prod;
    logic                               res_valid_reg;
    logic signed [wpid_pkg::OUT_W-1:0]  res_reg;
    logic signed [wpid_pkg::ACC_W-1:0]  acc;

    assign op_ready  = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb begin
        // Gains are unsigned; a zero sign bit makes them signed operands.
        prod.p = $signed({1'b0, gains.prop})  * op.err;
        prod.i = $signed({1'b0, gains.integ}) * op.sum;
        prod.d = $signed({1'b0, gains.deriv}) * op.diff;
        acc = wpid_pkg::ACC_W'(prod.p) + wpid_pkg::ACC_W'(prod.i)
            + wpid_pkg::ACC_W'(prod.d);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else begin
            if (op_ready) begin
                res_valid_reg <= op_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (op_valid && op_ready) begin
            res_reg <= acc[wpid_pkg::OUT_W-1:0];
        end
    end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the windowed PID line tracer. Light samples go
// in as stream beats, and an in-bench model of the error window and the
// three gain terms predicts every steering result. Each result beat is
// compared with the oldest prediction. Directed cases come first: reset
// defaults, gain and level extremes, and window wrap. Then come randomized
// phases with fresh register settings, random gaps and stalls on both
// streams, and a long receiver hold that backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // The run is ended by force well past the slowest legal run: about
    // 1800 beats, each with random idle gaps on either side, plus holds.
    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_IDLE    = 8;

    logic                              aclk        = 1'b0;
    logic                              aresetn     = 1'b0;
    logic                              s_tvalid    = 1'b0;
    logic                              s_tready;
    logic [wpid_pkg::S_TDATA_W-1:0]    s_tdata     = '0;   // light_sample[6:0], zero pad
    logic                              m_tvalid;
    logic                              m_tready    = 1'b0;
    logic [wpid_pkg::M_TDATA_W-1:0]    m_tdata;            // steer_fixed[26:0], zero pad
    logic                              cfg_wr_en   = 1'b0;
    logic [wpid_pkg::CFG_ADDR_W-1:0]   cfg_addr    = '0;
    logic [wpid_pkg::CFG_DATA_W-1:0]   cfg_wr_data = '0;

    windowed_pid_line_tracer i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // Controller model. These values mirror what the block holds after
    // reset: the defaults of the four registers, an all-zero window, and
    // no previous error yet.
    // ------------------------------------------------------------------
    logic [wpid_pkg::LEVEL_W-1:0]      cur_midpoint = '0;
    logic [wpid_pkg::GAIN_W-1:0]       cur_prop     = 16'd198;
    logic [wpid_pkg::GAIN_W-1:0]       cur_integ    = 16'd166;
    logic [wpid_pkg::GAIN_W-1:0]       cur_deriv    = 16'd96;
    logic signed [wpid_pkg::ERR_W-1:0] err_ring [wpid_pkg::WINDOW] = '{default: '0};
    int                                ring_slot    = 0;
    logic                              have_prev    = 1'b0;

    // Predicted steering values, oldest first.
    logic [wpid_pkg::OUT_W-1:0]        steer_expected [$];

    int                                fail_count   = 0;
    int                                cycle_count  = 0;

    // Pacing controls shared by the sender and the receiver. When a side is
    // not paced, it runs flat out. A nonzero hold request makes the receiver
    // drop m_tready for that many cycles after its next beat.
    logic                              feed_paced   = 1'b0;
    logic                              sink_paced   = 1'b0;
    int                                sink_hold_cycles = 0;

    // Advance the model by one sample and return the steering value it
    // produces. The new error goes into the ring first, so the window sum
    // already includes it. The derivative uses the error stored just before
    // it, which counts as zero on the very first sample after reset.
    function automatic logic [wpid_pkg::OUT_W-1:0] predict_steer(
        input logic [wpid_pkg::LEVEL_W-1:0] light);
        int     err_now;
        int     err_prev;
        int     win_sum;
        longint steer;
        err_now  = int'(cur_midpoint) - int'(light);
        err_prev = have_prev ?
            int'(err_ring[(ring_slot + wpid_pkg::WINDOW - 1) % wpid_pkg::WINDOW]) : 0;
        err_ring[ring_slot] = err_now[wpid_pkg::ERR_W-1:0];
        ring_slot = (ring_slot + 1) % wpid_pkg::WINDOW;
        have_prev = 1'b1;
        win_sum = 0;
        for (int k = 0; k < wpid_pkg::WINDOW; k++) begin
            win_sum += int'(err_ring[k]);
        end
        steer = longint'(cur_prop) * err_now
              + longint'(cur_integ) * win_sum
              + longint'(cur_deriv) * (err_now - err_prev);
        // The output wraps to its width in two's complement.
        return steer[wpid_pkg::OUT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Clock, watchdog and result checking.
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // All inputs change through nonblocking assignments at the rising edge.
    // Signals read here therefore still hold the values from before the
    // edge, which are the values that the handshake at this edge sees.
    always @(posedge aclk) begin
        logic [wpid_pkg::OUT_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (steer_expected.size() == 0) begin
                $error("steer_fixed: expected none, actual %0d",
                       $signed(m_tdata[wpid_pkg::OUT_W-1:0]));
                fail_count++;
            end else begin
                want = steer_expected.pop_front();
                if (m_tdata[wpid_pkg::OUT_W-1:0] !== want) begin
                    $error("steer_fixed: expected %0d, actual %0d",
                           $signed(want), $signed(m_tdata[wpid_pkg::OUT_W-1:0]));
                    fail_count++;
                end
            end
        end
    end

    // Result receiver. Before each beat it may wait a random number of
    // cycles with m_tready low. When a hold is requested, it first keeps
    // m_tready low for the whole requested stretch.
    initial begin : result_sink
        int unsigned idle;
        int          hold;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_hold_cycles > 0) begin
                hold = sink_hold_cycles;
                sink_hold_cycles = 0;
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            idle = sink_paced ? $urandom_range(0, MAX_IDLE) : 0;
            if (idle > 0) begin
                m_tready <= 1'b0;
                repeat (idle) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks.
    // ------------------------------------------------------------------

    // Offer one light sample, after a random gap when the sender is paced.
    // s_tvalid is lowered only when a gap actually follows, so a
    // back-to-back beat never sees valid dropped and raised in one step.
    // The prediction is made at the edge where the beat is taken.
    task automatic send_sample(input logic [wpid_pkg::LEVEL_W-1:0] light);
        int unsigned gap;
        gap = feed_paced ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(wpid_pkg::S_TDATA_W - wpid_pkg::LEVEL_W){1'b0}}, light};
        do @(posedge aclk); while (!s_tready);
        steer_expected.push_back(predict_steer(light));
    endtask

    // Stop offering samples and wait until every predicted result has come
    // back. A few more cycles let the two pipeline stages settle before
    // the registers are touched again.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (steer_expected.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // One register write. The model takes the new value at the same edge as
    // the block does. Only the low 7 bits of the midpoint word count.
    task automatic write_register(input logic [wpid_pkg::CFG_ADDR_W-1:0] idx,
                                  input logic [wpid_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        case (idx)
            wpid_pkg::REG_MIDPOINT: cur_midpoint = value[wpid_pkg::LEVEL_W-1:0];
            wpid_pkg::REG_PROP:     cur_prop     = value;
            wpid_pkg::REG_INTEG:    cur_integ    = value;
            wpid_pkg::REG_DERIV:    cur_deriv    = value;
            default: ;
        endcase
    endtask

    // Write all four registers back to back. This must only be called
    // while the block is idle.
    task automatic load_settings(input logic [wpid_pkg::CFG_DATA_W-1:0] midpoint_word,
                                 input logic [wpid_pkg::GAIN_W-1:0] prop,
                                 input logic [wpid_pkg::GAIN_W-1:0] integ,
                                 input logic [wpid_pkg::GAIN_W-1:0] deriv);
        write_register(wpid_pkg::REG_MIDPOINT, midpoint_word);
        write_register(wpid_pkg::REG_PROP, prop);
        write_register(wpid_pkg::REG_INTEG, integ);
        write_register(wpid_pkg::REG_DERIV, deriv);
        cfg_wr_en <= 1'b0;
    endtask

    // Random gain. Mostly small values, which are near the intended range,
    // with the extremes and full 16-bit values mixed in.
    function automatic logic [wpid_pkg::GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return wpid_pkg::GAIN_W'($urandom_range(0, 65535));
            default: return wpid_pkg::GAIN_W'($urandom_range(0, 512));
        endcase
    endfunction

    // Random midpoint word. It is usually inside 0..100, sometimes at the
    // edges of the 7-bit range, and sometimes has junk in the unused upper
    // bits of the write data.
    function automatic logic [wpid_pkg::CFG_DATA_W-1:0] pick_midpoint();
        logic [wpid_pkg::CFG_DATA_W-1:0] word;
        case ($urandom_range(0, 7))
            0:       word = 16'd0;
            1:       word = 16'd100;
            2:       word = 16'd127;
            default: word = wpid_pkg::CFG_DATA_W'($urandom_range(0, 100));
        endcase
        if ($urandom_range(0, 4) == 0) begin
            word[wpid_pkg::CFG_DATA_W-1:wpid_pkg::LEVEL_W] =
                (wpid_pkg::CFG_DATA_W - wpid_pkg::LEVEL_W)'($urandom);
        end
        return word;
    endfunction

    // Random sample. Most are in the sensor's 0..100 range. Some take any
    // 7-bit value, and some sit at full white or full black.
    function automatic logic [wpid_pkg::LEVEL_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return wpid_pkg::LEVEL_W'($urandom_range(0, 127));
            1:       return ($urandom_range(0, 1) != 0) ? 7'd100 : 7'd0;
            default: return wpid_pkg::LEVEL_W'($urandom_range(0, 100));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // These samples use the reset register values. The first beat has no
    // previous error, so its derivative term is the error alone. A sample
    // above 100 is also accepted.
    task automatic test_reset_defaults();
        send_sample(7'd0);
        send_sample(7'd100);
        send_sample(7'd127);
        send_sample(7'd50);
        send_sample(7'd1);
        drain_results();
    endtask

    // Full-scale gains with positive and negative errors, and a full swing
    // between samples so that the derivative term is wide. Then zero gains,
    // which must give a zero output.
    task automatic test_gain_extremes();
        load_settings(16'd100, '1, '1, '1);
        send_sample(7'd0);
        send_sample(7'd127);
        send_sample(7'd0);
        send_sample(7'd127);
        send_sample(7'd0);
        drain_results();

        // A midpoint of 127 against dark samples gives the largest positive
        // error, which then fills three of the five window slots.
        load_settings(16'd127, '1, '1, '1);
        send_sample(7'd0);
        send_sample(7'd0);
        send_sample(7'd0);
        drain_results();

        load_settings(16'd0, '0, '0, '0);
        send_sample(7'd127);
        send_sample(7'd64);
        drain_results();
    endtask

    // More samples than the window holds, with a distinct error for each.
    // The oldest error must leave the sum as the write slot wraps around.
    task automatic test_window_wrap();
        load_settings(16'd50, 16'd256, 16'd256, 16'd256);
        send_sample(7'd10);
        send_sample(7'd20);
        send_sample(7'd30);
        send_sample(7'd40);
        send_sample(7'd90);
        send_sample(7'd100);
        send_sample(7'd0);
        drain_results();
    endtask

    // Random traffic in phases. Each phase loads fresh register values and
    // picks how the two streams are paced. The first phases cover flat-out
    // traffic and pacing on one side only.
    task automatic test_random_phases();
        for (int phase = 0; phase < 12; phase++) begin
            load_settings(pick_midpoint(), pick_gain(), pick_gain(), pick_gain());
            case (phase)
                0: begin
                    feed_paced = 1'b0;
                    sink_paced = 1'b0;
                end
                1: begin
                    feed_paced = 1'b1;
                    sink_paced = 1'b0;
                end
                2: begin
                    feed_paced = 1'b0;
                    sink_paced = 1'b1;
                end
                default: begin
                    feed_paced = ($urandom_range(0, 3) != 0);
                    sink_paced = ($urandom_range(0, 3) != 0);
                end
            endcase
            repeat (140) send_sample(pick_sample());
            drain_results();
        end
    endtask

    // The receiver holds m_tready low for a long stretch while the sender
    // keeps offering beats. The pipeline fills, s_tready must drop, and
    // nothing may be lost or duplicated when the receiver starts again.
    task automatic test_backpressure();
        load_settings(pick_midpoint(), pick_gain(), pick_gain(), pick_gain());
        feed_paced = 1'b0;
        sink_paced = 1'b0;
        sink_hold_cycles = 80;
        repeat (40) send_sample(pick_sample());
        drain_results();
    endtask

    initial begin : test_sequence
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_gain_extremes();
        test_window_wrap();
        test_random_phases();
        test_backpressure();

        // Anything still in flight would show up as a late, unexpected beat.
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
